// ===== hw/rtl/rcd_pkg.sv =====
// rcd_pkg: shared types and constants for the recorder command decoder.
// No dependencies; imported by rcd_settings, recorder_command_decoder and the testbench.
package rcd_pkg;

	// table geometry (fixed by the port widths)
	localparam int CHANNELS    = 16;
	localparam int SPIKE_SLOTS = 4;
	localparam int CH_IW       = $clog2(CHANNELS);
	localparam int SLOT_IW     = $clog2(SPIKE_SLOTS);
	// word position saturates here
	localparam logic [4:0] POS_LIMIT = 5'(CHANNELS + SPIKE_SLOTS + 2);

	// transaction opcodes
	localparam logic [1:0] OP_WORD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// command heads
	localparam logic [15:0] HEAD_SAMPLE_ON  = 16'h0001;
	localparam logic [15:0] HEAD_SAMPLE_OFF = 16'h0002;
	localparam logic [15:0] HEAD_SAMPLE_STP = 16'h0003;
	localparam logic [15:0] HEAD_CHANNELS   = 16'h0200;
	localparam logic [15:0] HEAD_MODE       = 16'h0300;
	localparam logic [15:0] HEAD_SPIKE_CH   = 16'h0400;
	localparam logic [15:0] HEAD_SPIKE_SLOT = 16'h0500;

	localparam logic [7:0] MODE_LIMIT = 8'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] word;
		logic        last;
		logic [3:0]  index;
	} item_t;

	typedef struct packed {
		logic        sampling_on;
		logic [1:0]  sample_mode;
		logic        mode_changed;
		logic [4:0]  channel_count;
		logic [3:0]  spike_channel;
		logic [15:0] channel_entry;
		logic [15:0] threshold_entry;
		logic [3:0]  spike_slot_entry;
	} rd_t;

endpackage

// ===== hw/rtl/rcd_settings.sv =====
// rcd_settings: packet decode, settings registers and tables, read mux.
// Depends on rcd_pkg.
module rcd_settings import rcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  apply,
	input  item_t item,
	output rd_t   rd
);

	logic [15:0] head_q;
	logic [4:0]  pos_q;
	logic        sampling_q;
	logic [1:0]  mode_q;
	logic        mode_chg_q;
	logic [4:0]  count_q;
	logic [3:0]  spike_ch_q;
	logic        pick_q;
	logic [15:0] chan_tbl_q [CHANNELS];
	logic [15:0] thr_tbl_q  [CHANNELS];
	logic [3:0]  slot_q     [SPIKE_SLOTS];

	logic [7:0]  lb;
	logic [4:0]  pos_m1;
	logic        lb_ok;

	assign lb     = item.word[7:0];
	assign pos_m1 = pos_q - 5'd1;
	assign lb_ok  = lb < 8'(CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			pos_q      <= '0;
			sampling_q <= 1'b0;
			mode_q     <= '0;
			mode_chg_q <= 1'b0;
			count_q    <= '0;
			spike_ch_q <= '0;
			pick_q     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_tbl_q[i] <= '0;
				thr_tbl_q[i]  <= '0;
			end
			for (int i = 0; i < SPIKE_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (apply) begin
			case (item.op)
				OP_WORD: begin
					if (pos_q == 5'd0) begin
						head_q <= item.word;
						pos_q  <= 5'd1;
						case (item.word)
							HEAD_SAMPLE_ON: sampling_q <= 1'b1;
							HEAD_SAMPLE_OFF, HEAD_SAMPLE_STP: sampling_q <= 1'b0;
							HEAD_CHANNELS: count_q <= '0;
							HEAD_MODE: begin
								mode_chg_q <= 1'b1;
								sampling_q <= 1'b0;
							end
							HEAD_SPIKE_CH: pick_q <= 1'b0;
							default: ;
						endcase
					end else begin
						if (pos_q < POS_LIMIT)
							pos_q <= pos_q + 5'd1;
						case (head_q)
							HEAD_CHANNELS: begin
								if (pos_q <= 5'(CHANNELS) && lb_ok) begin
									chan_tbl_q[pos_m1[CH_IW-1:0]] <= item.word;
									count_q <= count_q + 5'd1;
								end
							end
							HEAD_MODE: begin
								if (pos_q == 5'd1 && lb < MODE_LIMIT)
									mode_q <= lb[1:0];
							end
							HEAD_SPIKE_CH: begin
								if (pos_q == 5'd1) begin
									pick_q <= lb_ok;
									if (lb_ok)
										spike_ch_q <= lb[3:0];
								end else if (pos_q == 5'd2 && pick_q) begin
									thr_tbl_q[spike_ch_q] <= item.word;
								end
							end
							HEAD_SPIKE_SLOT: begin
								if (pos_q <= 5'(SPIKE_SLOTS) && lb_ok)
									slot_q[pos_m1[SLOT_IW-1:0]] <= lb[3:0];
							end
							default: ;
						endcase
					end
					// a final word always rearms for a new head
					if (item.last)
						pos_q <= 5'd0;
				end
				OP_CLEAR: mode_chg_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_comb begin
		rd.sampling_on      = sampling_q;
		rd.sample_mode      = mode_q;
		rd.mode_changed     = mode_chg_q;
		rd.channel_count    = count_q;
		rd.spike_channel    = spike_ch_q;
		rd.channel_entry    = chan_tbl_q[item.index];
		rd.threshold_entry  = thr_tbl_q[item.index];
		rd.spike_slot_entry = slot_q[item.index[SLOT_IW-1:0]];
	end

endmodule

// ===== hw/rtl/recorder_command_decoder.sv =====
// recorder_command_decoder: top level; input register, settings block, result register.
// A read transaction passes through the input register and then the result register before it is presented.
// Throughput: one transaction per cycle; the only limit is a held result register.
// Reset (arst_n low, asynchronous): all settings, tables and handshake state clear.
// Depends on rcd_pkg and rcd_settings.
module recorder_command_decoder import rcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] word,
	input  logic        last,
	input  logic [3:0]  index,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sampling_on,
	output logic [1:0]  sample_mode,
	output logic        mode_changed,
	output logic [4:0]  channel_count,
	output logic [3:0]  spike_channel,
	output logic [15:0] channel_entry,
	output logic [15:0] threshold_entry,
	output logic [3:0]  spike_slot_entry
);

	// Stage 1 holds the accepted transaction. It retires into the settings
	// block in the cycle it advances; a read also loads the result register.
	logic  valid_s1;
	item_t item_s1;
	logic  is_read_s1;
	logic  adv_s1;
	logic  in_acc;
	rd_t   rd;
	rd_t   res_q;
	logic  out_valid_q;

	assign is_read_s1 = item_s1.op == OP_READ;
	// only a read needs room in the result register
	assign adv_s1 = valid_s1 && (!is_read_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.op    <= op;
			item_s1.word  <= word;
			item_s1.last  <= last;
			item_s1.index <= index;
		end
	end

	// settings, tables and the read mux; sees every transaction in order
	rcd_settings u_settings (
		.clk    (clk),
		.arst_n (arst_n),
		.apply  (adv_s1),
		.item   (item_s1),
		.rd     (rd)
	);

	// result register: reads sample state before this cycle's update,
	// which is right because a read changes nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_read_s1)
			res_q <= rd;
	end

	assign out_valid        = out_valid_q;
	assign sampling_on      = res_q.sampling_on;
	assign sample_mode      = res_q.sample_mode;
	assign mode_changed     = res_q.mode_changed;
	assign channel_count    = res_q.channel_count;
	assign spike_channel    = res_q.spike_channel;
	assign channel_entry    = res_q.channel_entry;
	assign threshold_entry  = res_q.threshold_entry;
	assign spike_slot_entry = res_q.spike_slot_entry;

`ifndef ASSERT_OFF
	// stage 1 only waits behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_stall) |-> (is_read_s1 && out_valid_q && out_stall))
		else $error("stage 1 stalled without a held result");

	// a retiring read always presents a result next cycle
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_read_s1) |=> out_valid_q)
		else $error("read retired without a result");

	// non-read transactions never create a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !(adv_s1 && is_read_s1)) |=> !out_valid_q)
		else $error("result appeared without a read");

	// channel count cannot pass the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (channel_count <= 5'(CHANNELS)))
		else $error("channel count out of range");
`endif

endmodule

// ===== verif/tb_recorder_command_decoder.sv =====
// tb_recorder_command_decoder: self-checking testbench for the recorder command decoder.
// Depends on rcd_pkg and the recorder_command_decoder RTL. Holds its own settings tracker,
// a queued driver, a randomly stalling receiver and a field-by-field read checker.
module tb_recorder_command_decoder import rcd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// op code 3 has no meaning; the block must take it and do nothing
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// cycles with no transaction on either side before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// the receiver's one long hold-off, and when it starts
	localparam int LONG_HOLD   = 48;
	localparam int HOLD_AT     = 150;
	// no idling once this few transactions are left to send
	localparam int QUIET_TAIL  = 80;
	localparam int RANDOM_ITEMS = 600;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_WORD;
	logic [15:0] word = '0;
	logic        last = 1'b0;
	logic [3:0]  index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        sampling_on;
	logic [1:0]  sample_mode;
	logic        mode_changed;
	logic [4:0]  channel_count;
	logic [3:0]  spike_channel;
	logic [15:0] channel_entry;
	logic [15:0] threshold_entry;
	logic [3:0]  spike_slot_entry;

	recorder_command_decoder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.word             (word),
		.last             (last),
		.index            (index),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.sampling_on      (sampling_on),
		.sample_mode      (sample_mode),
		.mode_changed     (mode_changed),
		.channel_count    (channel_count),
		.spike_channel    (spike_channel),
		.channel_entry    (channel_entry),
		.threshold_entry  (threshold_entry),
		.spike_slot_entry (spike_slot_entry)
	);

	// transactions waiting to be sent, and read results still owed by the block
	item_t pending_cmds[$];
	rd_t   expected_reads[$];

	int mismatches     = 0;
	int sent_count     = 0;
	int accepted_count = 0;
	int total_items    = 0;
	int idle_cycles    = 0;
	bit in_accepted    = 1'b0;  // set at each rising edge, read by the driver at the falling one

	// ---------------------------------------------------------------
	// Settings tracker: mirrors what the decoder should hold
	// ---------------------------------------------------------------
	logic [15:0] cur_head;
	logic [4:0]  word_pos;     // 0 = next word is a head
	logic        smp_flag;
	logic [1:0]  mode_val;
	logic        mode_chg;
	logic [4:0]  ch_count;
	logic [15:0] ch_tab [CHANNELS];
	logic [3:0]  spk_ch;
	logic [15:0] thr_tab [CHANNELS];
	logic [3:0]  slot_tab [SPIKE_SLOTS];
	logic        spk_pick_ok;  // word 1 of the last spike-channel packet was a real channel

	task automatic clear_settings();
		cur_head    = '0;
		word_pos    = '0;
		smp_flag    = 1'b0;
		mode_val    = '0;
		mode_chg    = 1'b0;
		ch_count    = '0;
		spk_ch      = '0;
		spk_pick_ok = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			ch_tab[i]  = '0;
			thr_tab[i] = '0;
		end
		for (int i = 0; i < SPIKE_SLOTS; i++)
			slot_tab[i] = '0;
	endtask

	// body word at position word_pos of the packet headed by cur_head
	task automatic apply_body_word(logic [15:0] w);
		logic [7:0] lb;
		lb = w[7:0];
		case (cur_head)
			HEAD_CHANNELS: begin
				if (word_pos >= 1 && word_pos <= CHANNELS && lb < CHANNELS) begin
					ch_tab[word_pos - 1] = w;
					ch_count++;
				end
			end
			HEAD_MODE: begin
				if (word_pos == 1 && lb < MODE_LIMIT)
					mode_val = lb[1:0];
			end
			HEAD_SPIKE_CH: begin
				if (word_pos == 1) begin
					if (lb < CHANNELS) begin
						spk_ch      = lb[3:0];
						spk_pick_ok = 1'b1;
					end else begin
						spk_pick_ok = 1'b0;
					end
				end else if (word_pos == 2 && spk_pick_ok) begin
					thr_tab[spk_ch] = w;
				end
			end
			HEAD_SPIKE_SLOT: begin
				if (word_pos >= 1 && word_pos <= SPIKE_SLOTS && lb < CHANNELS)
					slot_tab[word_pos - 1] = lb[3:0];
			end
			default: begin
			end
		endcase
	endtask

	// one accepted transaction: update the tracked settings, queue the read it owes
	task automatic update_settings(item_t it);
		rd_t want;
		case (it.op)
			OP_WORD: begin
				if (word_pos == 0) begin
					cur_head = it.word;
					case (it.word)
						HEAD_SAMPLE_ON:  smp_flag = 1'b1;
						HEAD_SAMPLE_OFF,
						HEAD_SAMPLE_STP: smp_flag = 1'b0;
						HEAD_CHANNELS:   ch_count = '0;
						HEAD_MODE: begin
							mode_chg = 1'b1;
							smp_flag = 1'b0;
						end
						HEAD_SPIKE_CH:   spk_pick_ok = 1'b0;
						default: begin
						end
					endcase
					word_pos = 5'd1;
				end else begin
					apply_body_word(it.word);
					if (word_pos < POS_LIMIT)
						word_pos++;
				end
				if (it.last)
					word_pos = '0;
			end
			OP_CLEAR: mode_chg = 1'b0;
			OP_READ: begin
				want.sampling_on   = smp_flag;
				want.sample_mode   = mode_val;
				want.mode_changed  = mode_chg;
				want.channel_count = ch_count;
				want.spike_channel = spk_ch;
				if (it.index < CHANNELS) begin
					want.channel_entry   = ch_tab[it.index];
					want.threshold_entry = thr_tab[it.index];
				end else begin
					want.channel_entry   = '0;
					want.threshold_entry = '0;
				end
				want.spike_slot_entry = slot_tab[it.index % SPIKE_SLOTS];
				expected_reads.push_back(want);
			end
			default: begin
				// unused op: taken and dropped
			end
		endcase
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic cmp_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic check_read(rd_t got);
		rd_t want;
		if (expected_reads.size() == 0) begin
			report_mismatch($sformatf("read result %h with none outstanding", got));
			return;
		end
		want = expected_reads.pop_front();
		cmp_field("sampling_on",      got.sampling_on,      want.sampling_on);
		cmp_field("sample_mode",      got.sample_mode,      want.sample_mode);
		cmp_field("mode_changed",     got.mode_changed,     want.mode_changed);
		cmp_field("channel_count",    got.channel_count,    want.channel_count);
		cmp_field("spike_channel",    got.spike_channel,    want.spike_channel);
		cmp_field("channel_entry",    got.channel_entry,    want.channel_entry);
		cmp_field("threshold_entry",  got.threshold_entry,  want.threshold_entry);
		cmp_field("spike_slot_entry", got.spike_slot_entry, want.spike_slot_entry);
	endtask

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------
	task automatic push_word(logic [15:0] w, logic l);
		item_t it;
		it.op    = OP_WORD;
		it.word  = w;
		it.last  = l;
		it.index = 4'($urandom_range(0, 15));  // don't-care for packet words
		pending_cmds.push_back(it);
	endtask

	task automatic push_read(logic [3:0] idx);
		item_t it;
		it.op    = OP_READ;
		it.word  = 16'($urandom_range(0, 65535));
		it.last  = 1'($urandom_range(0, 1));
		it.index = idx;
		pending_cmds.push_back(it);
	endtask

	task automatic push_other(logic [1:0] code);
		item_t it;
		it.op    = code;
		it.word  = 16'($urandom_range(0, 65535));
		it.last  = 1'($urandom_range(0, 1));
		it.index = 4'($urandom_range(0, 15));
		pending_cmds.push_back(it);
	endtask

	// body word: random high byte, low byte mostly below lim so the write lands
	function automatic logic [15:0] body_word(int lim);
		logic [7:0] lb;
		if ($urandom_range(0, 4) != 0)
			lb = 8'($urandom_range(0, lim - 1));
		else
			lb = 8'($urandom_range(0, 255));
		return {8'($urandom_range(0, 255)), lb};
	endfunction

	// head plus nbody body words; reads are sprinkled between the words, and
	// an unclosed packet swallows whatever follows as body
	task automatic queue_packet(logic [15:0] head, int nbody, int lim, bit close);
		push_word(head, close && nbody == 0);
		for (int k = 1; k <= nbody; k++) begin
			if ($urandom_range(0, 9) == 0)
				push_read(4'($urandom_range(0, 15)));
			push_word(body_word(lim), close && k == nbody);
		end
	endtask

	function automatic bit quiet_tail();
		return pending_cmds.size() < QUIET_TAIL;
	endfunction

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Driver: presents queued transactions at the falling edge, holds while stalled
	// ---------------------------------------------------------------
	int    send_gap = 0;
	item_t next_cmd;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_accepted) begin
			// stalled: payload stays put
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (pending_cmds.size() == 0) begin
			in_valid <= 1'b0;
		end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
			// idle burst
			in_valid <= 1'b0;
			send_gap = $urandom_range(0, 2);
		end else begin
			next_cmd = pending_cmds.pop_front();
			op       <= next_cmd.op;
			word     <= next_cmd.word;
			last     <= next_cmd.last;
			index    <= next_cmd.index;
			in_valid <= 1'b1;
			sent_count++;
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold-off that lets the
	// decoder fill up and push back on its input
	// ---------------------------------------------------------------
	int hold_left = 0;
	bit long_hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (!long_hold_done && sent_count >= HOLD_AT) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: samples both channels at the rising edge, predicts on input
	// transactions, checks result transactions, and runs the watchdog
	// ---------------------------------------------------------------
	item_t seen_cmd;
	rd_t   seen_read;
	bit    out_taken;

	always @(posedge clk) begin
		if (arst_n) begin
			in_accepted = in_valid && !in_stall;
			out_taken   = out_valid && !out_stall;
			// results are checked first; a read accepted now cannot return this cycle
			if (out_taken) begin
				seen_read = '{sampling_on, sample_mode, mode_changed, channel_count,
					spike_channel, channel_entry, threshold_entry, spike_slot_entry};
				check_read(seen_read);
			end
			if (in_accepted) begin
				seen_cmd = '{op, word, last, index};
				update_settings(seen_cmd);
				accepted_count++;
			end
			if (in_accepted || out_taken)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] ERROR: no transaction for %0d cycles", $realtime, STALL_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		logic [15:0] heads [7];
		logic [15:0] head;
		int sel;
		int nbody;
		int lim;

		heads = '{HEAD_SAMPLE_ON, HEAD_SAMPLE_OFF, HEAD_SAMPLE_STP, HEAD_CHANNELS,
			HEAD_MODE, HEAD_SPIKE_CH, HEAD_SPIKE_SLOT};
		clear_settings();

		// directed: reset values, each head but sample-off, the edge cases of each packet type
		push_read(4'd0);
		push_word(HEAD_SAMPLE_ON, 1'b1);             // head alone
		push_word(HEAD_MODE, 1'b0);
		push_word(16'hFF02, 1'b1);                   // mode 2, sampling dropped
		push_read(4'd3);
		push_other(OP_CLEAR);
		push_word(HEAD_CHANNELS, 1'b0);
		push_word(16'h000F, 1'b0);
		push_word(16'h0110, 1'b0);                   // low byte out of range: skipped
		push_word(16'hFF05, 1'b1);
		push_read(4'd0);
		push_word(HEAD_SPIKE_CH, 1'b0);
		push_word(16'h000F, 1'b0);
		push_word(16'hFFFF, 1'b1);                   // threshold of channel 15
		push_word(HEAD_SPIKE_CH, 1'b0);
		push_word(16'h0020, 1'b0);                   // bad channel: threshold not written
		push_word(16'h1234, 1'b1);
		push_read(4'd15);
		push_word(HEAD_SPIKE_SLOT, 1'b0);
		push_word(16'h0003, 1'b0);
		push_word(16'h00FF, 1'b0);
		push_word(16'h000A, 1'b0);
		push_word(16'h0001, 1'b0);
		push_word(16'hFFFF, 1'b1);                   // extra word ignored
		push_word(16'hFFFF, 1'b0);                   // unknown head
		push_word(HEAD_SAMPLE_ON, 1'b1);
		push_other(OP_UNUSED);
		push_word(HEAD_SAMPLE_STP, 1'b1);
		push_read(4'd6);

		// random: mostly well-formed packets with random content
		while (pending_cmds.size() < RANDOM_ITEMS + 30) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				if ($urandom_range(0, 19) != 0)
					head = heads[$urandom_range(0, 6)];
				else
					head = 16'($urandom_range(0, 65535));
				case (head)
					HEAD_CHANNELS: begin
						nbody = $urandom_range(0, CHANNELS + 2);
						lim = CHANNELS;
					end
					HEAD_MODE: begin
						nbody = $urandom_range(0, 2);
						lim = MODE_LIMIT;
					end
					HEAD_SPIKE_CH: begin
						nbody = $urandom_range(0, 3);
						lim = CHANNELS;
					end
					HEAD_SPIKE_SLOT: begin
						nbody = $urandom_range(0, SPIKE_SLOTS + 2);
						lim = CHANNELS;
					end
					default: begin
						nbody = $urandom_range(0, 2);
						lim = 256;
					end
				endcase
				// now and then run the position counter into saturation
				if ($urandom_range(0, 49) == 0)
					nbody = $urandom_range(POS_LIMIT, POS_LIMIT + 6);
				queue_packet(head, nbody, lim, $urandom_range(0, 11) != 0);
			end else if (sel < 85) begin
				push_read(4'($urandom_range(0, 15)));
			end else if (sel < 92) begin
				push_other(OP_CLEAR);
			end else if (sel < 95) begin
				push_other(OP_UNUSED);
			end else begin
				// stray word: lands wherever the packet state happens to be
				push_word(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
			end
		end
		total_items = pending_cmds.size();

		// reset: held from the start, released away from any clock edge
		repeat (12) @(posedge clk);
		#0.5 arst_n = 1'b1;

		// drain: every transaction in, every read back, then wait for strays
		while (accepted_count < total_items || expected_reads.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && expected_reads.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
